@@ design/memory_limit_range_carver_core_assert.svh @@
// Assertion macros shared by the range carver RTL.
`ifndef MEMORY_LIMIT_RANGE_CARVER_CORE_ASSERT_SVH
`define MEMORY_LIMIT_RANGE_CARVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MLRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MLRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mlrc_pkg.sv @@
// Constants, stage types and a helper function of the memory range carver.
package mlrc_pkg;

    localparam int ADDR_BITS = 48;
    localparam int SUM_BITS  = ADDR_BITS + 3;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_KERNEL_START   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_KERNEL_STOP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_RAMDISK_START  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_RAMDISK_LENGTH = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_INITIAL_BUDGET = 3'd4;

    localparam logic [1:0] CASE_NONE   = 2'd0;
    localparam logic [1:0] CASE_WHOLE  = 2'd1;
    localparam logic [1:0] CASE_KERNEL = 2'd2;
    localparam logic [1:0] CASE_PART   = 2'd3;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SUM_BITS-1:0]  sum_t;

    typedef struct packed {
        addr_t base;
        addr_t size;
        logic  in_k;
        logic  has_rd;
        addr_t klow;
        addr_t khigh;
        addr_t rhigh;
    } amt_t;

    typedef struct packed {
        amt_t amt;
        sum_t p3;
        sum_t p4;
        sum_t p5;
    } pfx_t;

    typedef struct packed {
        logic [1:0] code;
        logic       has_rd;
        addr_t      base;
        addr_t      len;
        addr_t      t_r;
        addr_t      t_kh;
        addr_t      t_kl;
        addr_t      t_rh;
        logic       cut;
        addr_t      bleft;
    } take_t;

    typedef struct packed {
        addr_t v0b;
        addr_t v0l;
        addr_t v1b;
        addr_t v1l;
        logic  cut;
        addr_t bleft;
        logic  merge;
    } vec_t;

    // Bytes granted from budget b to a request of a bytes once p bytes were asked before.
    function automatic addr_t clamp_take(input addr_t b, input sum_t p, input addr_t a);
        logic [SUM_BITS:0] d;
        addr_t             r;
        d = (SUM_BITS+1)'(b) - (SUM_BITS+1)'(p);
        if (d[SUM_BITS])
            r = '0;
        else if (d[SUM_BITS-1:0] >= SUM_BITS'(a))
            r = a;
        else
            r = d[ADDR_BITS-1:0];
        return r;
    endfunction

endpackage

@@ design/memory_limit_range_carver_core.sv @@
// Memory range carver: splits each physical range into kept vectors under a byte budget.
//
//  channel | direction | word contents (lowest bit first)
//  --------+-----------+---------------------------------------------------------------
//  s_*     | in        | tdata: span_base[47:0], span_size[95:48]
//  m_*     | out       | tdata: first_vec_base, first_vec_len, second_vec_base,
//          |           |        second_vec_len, budget_left; tuser: ramdisk_cut
//  cfg_*   | in        | cfg_index selects the register, cfg_data carries its value
//
//  Rate: one word per cycle in and out while m_tready stays high. The only feedback
//  loop is the budget register: one subtract and compare of the running budget against
//  prefix sums prepared in the two stages before it.
//  Reset: clears all valid bits, configuration registers and the running budget to zero.
//  Stalls: m_tready low holds the output word; s_tready drops only once all six stages
//  hold a word, and rises again in the cycle the output is taken.
//  Writing the initial budget register also reloads the running budget.
`include "memory_limit_range_carver_core_assert.svh"

module memory_limit_range_carver_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // span_base[47:0], span_size[95:48]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [2*mlrc_pkg::ADDR_BITS-1:0]     s_tdata,
    // first_vec_base, first_vec_len, second_vec_base, second_vec_len, budget_left
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [5*mlrc_pkg::ADDR_BITS-1:0]     m_tdata,
    // ramdisk_cut
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mlrc_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [mlrc_pkg::ADDR_BITS-1:0]       cfg_data
);

    // Configuration and running budget
    mlrc_pkg::addr_t kstart_reg, kstop_reg, rdstart_reg, rdlen_reg, budget_reg;
    mlrc_pkg::addr_t budget_next;
    // Values derived from configuration only, registered from the configuration registers
    mlrc_pkg::addr_t ksize_reg, rdend_reg;
    mlrc_pkg::addr_t ksize_next;
    mlrc_pkg::sum_t  pre2_reg;

    // Pipeline: input, amounts, prefix sums, takes, vectors, output
    logic in_valid_reg, a_valid_reg, p_valid_reg, c_valid_reg, d_valid_reg, out_valid_reg;
    mlrc_pkg::addr_t in_base_reg, in_size_reg;
    mlrc_pkg::amt_t  a_reg, a_next;
    mlrc_pkg::pfx_t  p_reg, p_next;
    mlrc_pkg::take_t c_reg, c_next;
    mlrc_pkg::vec_t  d_reg, d_next, out_reg, out_next;

    logic s_fire, cfg_fire;
    logic rdy_out, rdy_d, rdy_c, rdy_p, rdy_a;
    logic adv_d, adv_c, adv_p, adv_a, adv_in;

    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire = cfg_valid && cfg_ready;

    // Ready chain: a stage advances when the next one is empty or advancing too
    assign rdy_out  = !out_valid_reg || m_tready;
    assign adv_d    = d_valid_reg && rdy_out;
    assign rdy_d    = !d_valid_reg || rdy_out;
    assign adv_c    = c_valid_reg && rdy_d;
    assign rdy_c    = !c_valid_reg || rdy_d;
    assign adv_p    = p_valid_reg && rdy_c;
    assign rdy_p    = !p_valid_reg || rdy_c;
    assign adv_a    = a_valid_reg && rdy_p;
    assign rdy_a    = !a_valid_reg || rdy_p;
    assign adv_in   = in_valid_reg && rdy_a;
    assign s_tready = !in_valid_reg || rdy_a;

    // Configuration writes; the running budget takes the item update between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kstart_reg  <= '0;
            kstop_reg   <= '0;
            rdstart_reg <= '0;
            rdlen_reg   <= '0;
            budget_reg  <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    mlrc_pkg::REG_KERNEL_START:   kstart_reg  <= cfg_data;
                    mlrc_pkg::REG_KERNEL_STOP:    kstop_reg   <= cfg_data;
                    mlrc_pkg::REG_RAMDISK_START:  rdstart_reg <= cfg_data;
                    mlrc_pkg::REG_RAMDISK_LENGTH: rdlen_reg   <= cfg_data;
                    mlrc_pkg::REG_INITIAL_BUDGET: budget_reg  <= cfg_data;
                    default: ;
                endcase
            end
            else if (adv_p)
            begin
                budget_reg <= budget_next;
            end
        end
    end

    // Kernel size wraps at the address width before it joins the wider prefix sum
    assign ksize_next = kstop_reg - kstart_reg;

    always_ff @(posedge clk)
    begin
        ksize_reg <= ksize_next;
        rdend_reg <= rdstart_reg + rdlen_reg;
        pre2_reg  <= mlrc_pkg::SUM_BITS'(ksize_next)
                     + mlrc_pkg::SUM_BITS'(rdlen_reg);
    end

    // Amounts stage: range end, kernel test and the three gap sizes
    always_comb
    begin
        mlrc_pkg::addr_t rend;
        rend          = in_base_reg + in_size_reg;
        a_next.base   = in_base_reg;
        a_next.size   = in_size_reg;
        a_next.in_k   = (in_base_reg <= kstart_reg) && (kstart_reg < rend);
        a_next.has_rd = (rdlen_reg != '0);
        a_next.klow   = kstart_reg - in_base_reg;
        a_next.khigh  = a_next.has_rd ? (rdstart_reg - kstop_reg) : (rend - kstop_reg);
        a_next.rhigh  = a_next.has_rd ? (rend - rdend_reg) : '0;
    end

    // Prefix sums of the requests, in the order the budget serves them
    always_comb
    begin
        p_next.amt = a_reg;
        p_next.p3  = pre2_reg + mlrc_pkg::SUM_BITS'(a_reg.khigh);
        p_next.p4  = pre2_reg + mlrc_pkg::SUM_BITS'(a_reg.khigh)
                     + mlrc_pkg::SUM_BITS'(a_reg.klow);
        p_next.p5  = pre2_reg + mlrc_pkg::SUM_BITS'(a_reg.khigh)
                     + mlrc_pkg::SUM_BITS'(a_reg.klow) + mlrc_pkg::SUM_BITS'(a_reg.rhigh);
    end

    // Budget stage: every take is the budget beyond its prefix, clamped to its request
    always_comb
    begin
        c_next.has_rd = p_reg.amt.has_rd;
        c_next.base   = p_reg.amt.base;
        c_next.t_r    = mlrc_pkg::clamp_take(budget_reg,
                                             mlrc_pkg::SUM_BITS'(ksize_reg), rdlen_reg);
        c_next.t_kh   = mlrc_pkg::clamp_take(budget_reg, pre2_reg, p_reg.amt.khigh);
        c_next.t_kl   = mlrc_pkg::clamp_take(budget_reg, p_reg.p3, p_reg.amt.klow);
        c_next.t_rh   = mlrc_pkg::clamp_take(budget_reg, p_reg.p4, p_reg.amt.rhigh);
        c_next.cut    = p_reg.amt.has_rd && (mlrc_pkg::SUM_BITS'(budget_reg) < pre2_reg);
        if (budget_reg == '0)
        begin
            c_next.code = mlrc_pkg::CASE_NONE;
            c_next.len  = '0;
            budget_next = budget_reg;
        end
        else if (p_reg.amt.size <= budget_reg)
        begin
            c_next.code = mlrc_pkg::CASE_WHOLE;
            c_next.len  = p_reg.amt.size;
            budget_next = budget_reg - p_reg.amt.size;
        end
        else if (p_reg.amt.in_k)
        begin
            c_next.code = mlrc_pkg::CASE_KERNEL;
            c_next.len  = '0;
            budget_next = (mlrc_pkg::SUM_BITS'(budget_reg) >= p_reg.p5)
                        ? mlrc_pkg::ADDR_BITS'(mlrc_pkg::SUM_BITS'(budget_reg) - p_reg.p5)
                        : '0;
        end
        else
        begin
            // Range misses the kernel: the rest of the budget goes from its base
            c_next.code = mlrc_pkg::CASE_PART;
            c_next.len  = budget_reg;
            budget_next = '0;
        end
        c_next.bleft = budget_next;
    end

    // Vector stage: place both vectors and test whether they touch
    always_comb
    begin
        d_next.bleft = c_reg.bleft;
        unique case (c_reg.code)
            mlrc_pkg::CASE_NONE:
            begin
                d_next.v0b   = '0;
                d_next.v0l   = '0;
                d_next.v1b   = '0;
                d_next.v1l   = '0;
                d_next.cut   = 1'b0;
                d_next.merge = 1'b0;
            end
            mlrc_pkg::CASE_WHOLE, mlrc_pkg::CASE_PART:
            begin
                d_next.v0b   = c_reg.base;
                d_next.v0l   = c_reg.len;
                d_next.v1b   = '0;
                d_next.v1l   = '0;
                d_next.cut   = 1'b0;
                d_next.merge = 1'b0;
            end
            mlrc_pkg::CASE_KERNEL:
            begin
                d_next.v0b   = kstart_reg - c_reg.t_kl;
                d_next.v0l   = ksize_reg + c_reg.t_kh + c_reg.t_kl;
                d_next.v1b   = c_reg.has_rd ? rdstart_reg : '0;
                d_next.v1l   = c_reg.t_r + c_reg.t_rh;
                d_next.cut   = c_reg.cut;
                // First vector ends at kernel end plus the upper growth
                d_next.merge = c_reg.has_rd && ((kstop_reg + c_reg.t_kh) == rdstart_reg);
            end
        endcase
    end

    // Output stage: fold the second vector into the first where they touch
    always_comb
    begin
        out_next = d_reg;
        if (d_reg.merge)
        begin
            out_next.v0l = d_reg.v0l + d_reg.v1l;
            out_next.v1b = '0;
            out_next.v1l = '0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (adv_in)
                in_valid_reg <= 1'b0;
            if (adv_in)
                a_valid_reg <= 1'b1;
            else if (adv_a)
                a_valid_reg <= 1'b0;
            if (adv_a)
                p_valid_reg <= 1'b1;
            else if (adv_p)
                p_valid_reg <= 1'b0;
            if (adv_p)
                c_valid_reg <= 1'b1;
            else if (adv_c)
                c_valid_reg <= 1'b0;
            if (adv_c)
                d_valid_reg <= 1'b1;
            else if (adv_d)
                d_valid_reg <= 1'b0;
            if (adv_d)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: load each stage as its predecessor advances, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_base_reg <= s_tdata[mlrc_pkg::ADDR_BITS-1:0];
            in_size_reg <= s_tdata[2*mlrc_pkg::ADDR_BITS-1:mlrc_pkg::ADDR_BITS];
        end
        if (adv_in)
            a_reg <= a_next;
        if (adv_a)
            p_reg <= p_next;
        if (adv_p)
            c_reg <= c_next;
        if (adv_c)
            d_reg <= d_next;
        if (adv_d)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.bleft, out_reg.v1l, out_reg.v1b, out_reg.v0l, out_reg.v0b};
    assign m_tuser  = out_reg.cut;

    `MLRC_ASSERT_NEXT(a_budget_no_growth,
        !(cfg_fire && (cfg_index == mlrc_pkg::REG_INITIAL_BUDGET)),
        budget_reg <= $past(budget_reg),
        "running budget grew without a budget write")
    `MLRC_ASSERT_NEXT(a_budget_idle_hold, !cfg_fire && !adv_p, $stable(budget_reg),
        "running budget moved with no item in the budget stage")
    `MLRC_ASSERT_NOW(a_cut_drains_budget, m_tvalid && m_tuser[0],
        m_tdata[5*mlrc_pkg::ADDR_BITS-1:4*mlrc_pkg::ADDR_BITS] == '0,
        "ramdisk cut but budget left over")
    `MLRC_ASSERT_NOW(a_second_needs_ramdisk,
        m_tvalid && (m_tdata[4*mlrc_pkg::ADDR_BITS-1:3*mlrc_pkg::ADDR_BITS] != '0),
        rdlen_reg != '0,
        "second vector formed with no ramdisk")

endmodule

@@ sim/tb_memory_limit_range_carver_core.sv @@
// Self-checking testbench for the memory range carver: directed table, random spans, scoreboard.
module tb_memory_limit_range_carver_core;

    import mlrc_pkg::*;

    // Clock period is 12 units, so the half period is 6.
    localparam int    HALF_PERIOD  = 6;
    localparam int    RESET_CYCLES = 9;
    // Cycles without any handshake before the run is declared hung. The long receiver
    // hold-off below is far shorter than this.
    localparam int    QUIET_LIMIT  = 2000;
    localparam int    CHOKE_CYCLES = 240;
    // Six pipeline stages; leave a margin after the last result for stray words.
    localparam int    TAIL_CYCLES  = 16;
    localparam int    MODES        = 3;
    localparam int    SEGMENTS     = 10;
    localparam int    SEG_SPANS    = 20;
    localparam addr_t ALL_ONES     = '1;

    // One result word, field by field.
    typedef struct packed {
        addr_t first_base;
        addr_t first_len;
        addr_t second_base;
        addr_t second_len;
        logic  cut;
        addr_t left;
    } carve_t;

    typedef enum logic {ROW_CFG, ROW_SPAN} row_kind_e;

    // A directed row is either a register write (idx, a) or a span (a = base, b = size).
    // Where typed is set, want is the result read straight off the behaviour.
    typedef struct packed {
        row_kind_e           kind;
        logic [IDX_BITS-1:0] idx;
        addr_t               a;
        addr_t               b;
        logic                typed;
        carve_t              want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [2*ADDR_BITS-1:0]    s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [5*ADDR_BITS-1:0]    m_tdata;
    logic [0:0]                m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [IDX_BITS-1:0]       cfg_index;
    addr_t                     cfg_data;

    // Shadow registers and running budget of the carver.
    addr_t kern_base;
    addr_t kern_end;
    addr_t rd_base;
    addr_t rd_len;
    addr_t budget_now;

    // Results still owed by the block, oldest first.
    carve_t pending [$];

    int          send_gap_pct;
    int          recv_gap_pct;
    bit          choke_req;
    int          errors;
    int unsigned spans_sent;
    int unsigned words_seen;
    int unsigned reg_writes;
    int unsigned kernel_hits;
    int unsigned merges;
    int unsigned cuts;

    // Directed table: zero budget after reset, the extremes, kernel with and without a
    // ramdisk, merge, truncated ramdisk, a kernel larger than the budget, a wrapping range,
    // a kernel whose stop lies below its start, and an all-ones ramdisk length.
    plan_row_t plan [0:27] = '{
        '{ROW_SPAN, REG_KERNEL_START,   ALL_ONES,           ALL_ONES,  1'b1, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h0,              48'h0,     1'b1, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, ALL_ONES,           48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   ALL_ONES,           48'h0,     1'b1,
          '{ALL_ONES, 48'h0, 48'h0, 48'h0, 1'b0, ALL_ONES}},
        '{ROW_SPAN, REG_KERNEL_START,   48'h0,              ALL_ONES,  1'b1,
          '{48'h0, ALL_ONES, 48'h0, 48'h0, 1'b0, 48'h0}},
        '{ROW_SPAN, REG_KERNEL_START,   48'h1234,           48'h1,     1'b1, '0},
        '{ROW_CFG,  REG_KERNEL_START,   48'h1000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_KERNEL_STOP,    48'h2000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h30000,          48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h800,            48'h100000, 1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h200000,         48'h100000, 1'b0, '0},
        '{ROW_CFG,  REG_RAMDISK_START,  48'h4000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_RAMDISK_LENGTH, 48'h2000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h30000,          48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h0,              48'h100000, 1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h1800,           48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h0,              48'h100000, 1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h800,            48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h1000,           48'h10000, 1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h10000,          48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'hFFFF_FFFF_0000, 48'h20000, 1'b0, '0},
        '{ROW_CFG,  REG_KERNEL_START,   48'h8000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_KERNEL_STOP,    48'h4000,           48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h0,              48'h100000, 1'b0, '0},
        '{ROW_CFG,  REG_KERNEL_STOP,    48'h9000,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_RAMDISK_LENGTH, ALL_ONES,           48'h0,     1'b0, '0},
        '{ROW_CFG,  REG_INITIAL_BUDGET, 48'h10000,          48'h0,     1'b0, '0},
        '{ROW_SPAN, REG_KERNEL_START,   48'h7FFF,           48'h100000, 1'b0, '0}
    };

    memory_limit_range_carver_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Grant up to amount bytes from the running budget, saturating at zero.
    function automatic addr_t draw(input addr_t amount);
        addr_t got;
        got = (budget_now < amount) ? budget_now : amount;
        budget_now -= got;
        return got;
    endfunction

    // Carve one span under the running budget; all address sums wrap at ADDR_BITS.
    function automatic carve_t carve_span(input addr_t base, input addr_t size);
        carve_t res;
        addr_t  span_end;
        addr_t  below;
        addr_t  above_kern;
        addr_t  above_rd;
        addr_t  got;
        res = '0;
        if (budget_now != '0)
        begin
            span_end = base + size;
            if (size <= budget_now)
            begin
                // Budget covers the whole span: keep it all.
                res.first_base = base;
                res.first_len  = size;
                budget_now    -= size;
            end
            else if (base <= kern_base && kern_base < span_end)
            begin
                kernel_hits++;
                below          = kern_base - base;
                above_kern     = span_end - kern_end;
                above_rd       = '0;
                // Kernel is kept whole even when it overdraws the budget.
                res.first_base = kern_base;
                res.first_len  = kern_end - kern_base;
                budget_now     = (budget_now > res.first_len) ? budget_now - res.first_len : '0;
                if (rd_len != '0)
                begin
                    got             = draw(rd_len);
                    res.cut         = (got != rd_len);
                    res.second_base = rd_base;
                    res.second_len  = got;
                    above_kern      = rd_base - kern_end;
                    above_rd        = span_end - (rd_base + rd_len);
                end
                // Grow after the kernel, then before it, then after the ramdisk.
                res.first_len  += draw(above_kern);
                got             = draw(below);
                res.first_base -= got;
                res.first_len  += got;
                res.second_len += draw(above_rd);
                if (addr_t'(res.first_base + res.first_len) == res.second_base)
                begin
                    merges++;
                    res.first_len  += res.second_len;
                    res.second_base = '0;
                    res.second_len  = '0;
                end
                if (res.cut)
                    cuts++;
            end
            else
            begin
                res.first_base = base;
                res.first_len  = draw(size);
            end
        end
        res.left = budget_now;
        return res;
    endfunction

    function automatic addr_t wide_rand();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    // Offer one span word; on acceptance, queue what the block owes for it.
    task automatic offer_span(input addr_t base, input addr_t size, input logic typed,
                              input carve_t want);
        carve_t owed;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {size, base};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Advance the shadow budget even when the expectation is typed in.
        owed = carve_span(base, size);
        pending.push_back(typed ? want : owed);
        spans_sent++;
    endtask

    // Write one register and mirror it into the shadow copy; valid is left for the
    // next driver of the channel to lower.
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input addr_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KERNEL_START:   kern_base = val;
            REG_KERNEL_STOP:    kern_end  = val;
            REG_RAMDISK_START:  rd_base   = val;
            REG_RAMDISK_LENGTH: rd_len    = val;
            REG_INITIAL_BUDGET: budget_now = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drop the span channel and hold until every owed word has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input addr_t want, input addr_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Receiver: sample the output channel, compare against the oldest owed word,
    // then pick the next ready level. A hold-off request parks ready low for a long
    // stretch, counted here, so the pipeline backs up into the span channel.
    initial
    begin : receiver
        carve_t want;
        int     choke_left;
        choke_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none, actual %h / %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = pending.pop_front();
                    words_seen++;
                    check_field("first_vec_base", want.first_base,
                                m_tdata[0*ADDR_BITS +: ADDR_BITS]);
                    check_field("first_vec_len", want.first_len,
                                m_tdata[1*ADDR_BITS +: ADDR_BITS]);
                    check_field("second_vec_base", want.second_base,
                                m_tdata[2*ADDR_BITS +: ADDR_BITS]);
                    check_field("second_vec_len", want.second_len,
                                m_tdata[3*ADDR_BITS +: ADDR_BITS]);
                    check_field("budget_left", want.left,
                                m_tdata[4*ADDR_BITS +: ADDR_BITS]);
                    check_field("ramdisk_cut", addr_t'(want.cut), addr_t'(m_tuser));
                end
            end
            if (choke_left != 0)
            begin
                choke_left--;
                m_tready <= 1'b0;
            end
            else if (choke_req)
            begin
                choke_req  = 1'b0;
                choke_left = CHOKE_CYCLES;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog: count cycles in which no channel moves a word.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t no word moved for %0d cycles, %0d words still owed",
                         $time, QUIET_LIMIT, pending.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random segments under three idling mixes.
    initial
    begin : stimulus
        int    mode;
        int    seg;
        int    n;
        int    pick;
        bit    edgy;
        addr_t base;
        addr_t size;
        addr_t off;
        addr_t kb;
        addr_t ke;
        addr_t rs;
        addr_t rl;
        addr_t bud;

        // Drive every input to a known level before reset lifts.
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_KERNEL_START;
        cfg_data  = '0;
        choke_req = 1'b0;
        errors    = 0;
        kern_base = '0;
        kern_end  = '0;
        rd_base   = '0;
        rd_len    = '0;
        budget_now = '0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        spans_sent = 0;
        words_seen = 0;
        reg_writes = 0;
        kernel_hits = 0;
        merges = 0;
        cuts = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; registers change only once the block has drained.
        send_gap_pct = 36;
        recv_gap_pct = 51;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].a);
            end
            else
                offer_span(plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
        end

        for (mode = 0; mode < MODES; mode++)
        begin
            // Receiver-heavy gaps first, then sender-heavy, then none at all.
            send_gap_pct = (mode == 0) ? 36 : (mode == 1) ? 51 : 0;
            recv_gap_pct = (mode == 0) ? 51 : (mode == 1) ? 36 : 0;
            for (seg = 0; seg < SEGMENTS; seg++)
            begin
                // Hold the sender until the block is empty, then reload every register.
                settle();
                edgy = (seg == 3 || seg == 7);
                kb = ($urandom_range(0, 3) == 0) ? wide_rand()
                                                 : addr_t'($urandom_range(32'h100000, 32'h7FFFFFFF));
                ke = kb + addr_t'($urandom_range(0, 32'h8000));
                if ($urandom_range(0, 15) == 0)
                    ke = wide_rand();
                pick = $urandom_range(0, 2);
                rs = (pick == 0) ? ke
                   : (pick == 1) ? ke + addr_t'($urandom_range(0, 32'h8000)) : wide_rand();
                rl = ($urandom_range(0, 3) == 0) ? '0 : addr_t'($urandom_range(1, 32'h8000));
                if ($urandom_range(0, 15) == 0)
                    rl = wide_rand();
                pick = $urandom_range(0, 9);
                bud = (pick < 4) ? addr_t'($urandom_range(1, 32'h4000))
                    : (pick < 7) ? addr_t'($urandom_range(32'h4000, 32'h40000))
                    : (pick == 7) ? wide_rand() : (pick == 8) ? ALL_ONES : '0;
                if (edgy)
                begin
                    kb  = $urandom_range(0, 1) ? ALL_ONES : '0;
                    ke  = $urandom_range(0, 1) ? ALL_ONES : '0;
                    rs  = $urandom_range(0, 1) ? ALL_ONES : '0;
                    rl  = $urandom_range(0, 1) ? ALL_ONES : '0;
                    bud = $urandom_range(0, 1) ? ALL_ONES : '0;
                end
                write_reg(REG_KERNEL_START, kb);
                write_reg(REG_KERNEL_STOP, ke);
                write_reg(REG_RAMDISK_START, rs);
                write_reg(REG_RAMDISK_LENGTH, rl);
                write_reg(REG_INITIAL_BUDGET, bud);

                // With nobody idling, stall the receiver for a long stretch so the
                // pipeline fills and the span channel backs up.
                if (mode == MODES - 1 && seg == 5)
                    choke_req = 1'b1;

                for (n = 0; n < SEG_SPANS; n++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                    begin
                        // Span around the kernel, usually larger than the budget.
                        off  = addr_t'($urandom_range(0, 32'h10000));
                        base = (kern_base >= off) ? kern_base - off : '0;
                        size = (kern_base - base) + addr_t'($urandom_range(1, 32'h40000));
                    end
                    else if (pick < 80)
                    begin
                        base = wide_rand();
                        size = wide_rand();
                    end
                    else
                    begin
                        base = wide_rand();
                        size = addr_t'($urandom_range(0, 32'h8000));
                    end
                    offer_span(base, size, 1'b0, '0);
                end
            end
        end

        // Drain, then leave room for any stray word the block might still emit.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d spans and %0d register writes, %0d result words checked",
                 spans_sent, reg_writes, words_seen);
        $display("kernel carves %0d, vector merges %0d, ramdisk cuts %0d, mismatches %0d",
                 kernel_hits, merges, cuts, errors);
        if (errors == 0 && pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/mlrc_pkg.sv
design/memory_limit_range_carver_core.sv
sim/tb_memory_limit_range_carver_core.sv
